[hdl/crde_pkg.sv]
`default_nettype none
package crde_pkg;

	localparam logic [2:0] KIND_RAW   = 3'd0;
	localparam logic [2:0] KIND_HALF  = 3'd1;
	localparam logic [2:0] KIND_RANGE = 3'd2;
	localparam logic [2:0] KIND_UNIT  = 3'd3;
	localparam logic [2:0] KIND_SPLIT = 3'd4;

	localparam logic [63:0] GOLDEN_C = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] DRAW_C   = 64'hD1B54A32D192ED03;
	localparam logic [63:0] MIX1_C   = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX2_C   = 64'h94D049BB133111EB;

	localparam int unsigned DIV_STEPS = 64;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SEED,
		OP_MUL0,
		OP_MUL1,
		OP_MUL2,
		OP_XOR_ACC,
		OP_MIX_ADD,
		OP_SH27,
		OP_SH31,
		OP_DIV_THR,
		OP_DIV_MOD,
		OP_DIV_STEP,
		OP_SAVE_THR,
		OP_IDX_INC,
		OP_OUT
	} dp_op_t;

	typedef enum logic [1:0] {
		MS_IDENT,
		MS_IDX,
		MS_MIX1,
		MS_MIX2
	} mul_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SEED,
		ST_M1,
		ST_X1,
		ST_M2,
		ST_X2,
		ST_MIX,
		ST_M3,
		ST_X3,
		ST_M4,
		ST_X4,
		ST_EVAL,
		ST_THR_INIT,
		ST_THR_DIV,
		ST_THR_SAVE,
		ST_MOD_INIT,
		ST_MOD_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		dp_op_t   op;
		mul_sel_t msel;
		logic     exhausted;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       empty;
		logic       draw_ge_thr;
		logic       out_free;
	} dp_status_t;

endpackage
`default_nettype wire

[hdl/crde_dp.sv]
`default_nettype none
module crde_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire crde_pkg::dp_cmd_t    cmd,
	output crde_pkg::dp_status_t      status,
	input  wire logic [383:0]         s_tdata,
	input  wire logic [2:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [127:0]              m_tdata,
	output logic [0:0]                m_tuser
);

	logic [2:0]   kind_q;
	logic [63:0]  seed_q, ident_q, idx_q, lo_q, n_q, child_q;
	logic         empty_q;
	logic [63:0]  x_q, acc_q, thr_q, rem_q, dvd_q;
	logic         valid_q;
	logic [127:0] odata_q;
	logic         oflag_q;

	logic [63:0]  mul_a, mul_b, mix_t;
	logic [31:0]  mop_a, mop_b;
	logic [63:0]  prod;
	logic [64:0]  div_r, div_d;

	always_comb begin
		unique case (cmd.msel)
			crde_pkg::MS_IDENT: begin
				mul_a = ident_q;
				mul_b = crde_pkg::GOLDEN_C;
			end
			crde_pkg::MS_IDX: begin
				mul_a = idx_q;
				mul_b = crde_pkg::DRAW_C;
			end
			crde_pkg::MS_MIX1: begin
				mul_a = x_q;
				mul_b = crde_pkg::MIX1_C;
			end
			default: begin
				mul_a = x_q;
				mul_b = crde_pkg::MIX2_C;
			end
		endcase
		// low half of a 64x64 product: lo*lo, then the two cross terms
		mop_a = (cmd.op == crde_pkg::OP_MUL2) ? mul_a[63:32] : mul_a[31:0];
		mop_b = (cmd.op == crde_pkg::OP_MUL1) ? mul_b[63:32] : mul_b[31:0];
		prod  = {32'd0, mop_a} * {32'd0, mop_b};
		mix_t = x_q + crde_pkg::GOLDEN_C;
		div_r = {rem_q, dvd_q[63]};
		div_d = {1'b0, n_q};
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			crde_pkg::OP_LOAD: begin
				kind_q  <= s_tuser;
				seed_q  <= s_tdata[63:0];
				ident_q <= s_tdata[127:64];
				idx_q   <= s_tdata[191:128];
				lo_q    <= s_tdata[255:192];
				n_q     <= s_tdata[319:256] - s_tdata[255:192];
				empty_q <= s_tdata[319:256] <= s_tdata[255:192];
				child_q <= s_tdata[383:320];
				x_q     <= s_tdata[63:0];
			end
			crde_pkg::OP_SEED:    x_q   <= seed_q;
			crde_pkg::OP_MUL0:    acc_q <= prod;
			crde_pkg::OP_MUL1,
			crde_pkg::OP_MUL2:    acc_q <= acc_q + {prod[31:0], 32'd0};
			crde_pkg::OP_XOR_ACC: x_q   <= x_q ^ acc_q;
			crde_pkg::OP_MIX_ADD: x_q   <= mix_t ^ (mix_t >> 30);
			crde_pkg::OP_SH27:    x_q   <= acc_q ^ (acc_q >> 27);
			crde_pkg::OP_SH31:    x_q   <= acc_q ^ (acc_q >> 31);
			crde_pkg::OP_DIV_THR: begin
				dvd_q <= 64'd0 - n_q;
				rem_q <= 64'd0;
			end
			crde_pkg::OP_DIV_MOD: begin
				dvd_q <= x_q;
				rem_q <= 64'd0;
			end
			crde_pkg::OP_DIV_STEP: begin
				dvd_q <= {dvd_q[62:0], 1'b0};
				if (div_r >= div_d) begin
					rem_q <= 64'(div_r - div_d);
				end else begin
					rem_q <= div_r[63:0];
				end
			end
			crde_pkg::OP_SAVE_THR: thr_q <= rem_q;
			crde_pkg::OP_IDX_INC:  idx_q <= idx_q + 64'd1;
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.op == crde_pkg::OP_OUT) begin
			oflag_q <= 1'b0;
			case (kind_q)
				crde_pkg::KIND_RAW:  odata_q <= {64'd0, x_q};
				crde_pkg::KIND_HALF: odata_q <= {64'd0, 32'd0, x_q[63:32]};
				crde_pkg::KIND_UNIT: odata_q <= {64'd0, 40'd0, x_q[63:40]};
				crde_pkg::KIND_SPLIT: odata_q <= {child_q, x_q};
				crde_pkg::KIND_RANGE: begin
					if (empty_q) begin
						odata_q <= {64'd0, lo_q};
					end else begin
						odata_q <= {64'd0, lo_q + rem_q};
						oflag_q <= cmd.exhausted;
					end
				end
				default: odata_q <= 128'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.op == crde_pkg::OP_OUT) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = oflag_q;

	assign status.kind        = kind_q;
	assign status.empty       = empty_q;
	assign status.draw_ge_thr = x_q >= thr_q;
	assign status.out_free    = !valid_q || m_tready;

endmodule
`default_nettype wire

[hdl/crde_ctrl.sv]
`default_nettype none
module crde_ctrl #(
	parameter int unsigned MAX_TRIES = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	output crde_pkg::dp_cmd_t         cmd,
	input  wire crde_pkg::dp_status_t status
);

	localparam int unsigned TW = (MAX_TRIES > 2) ? $clog2(MAX_TRIES) : 1;
	localparam logic [TW-1:0] LAST_TRY = TW'(MAX_TRIES - 1);
	localparam logic [5:0] LAST_STEP = 6'(crde_pkg::DIV_STEPS - 1);

	crde_pkg::state_t state_q, state_d;
	logic [1:0]    ph_q, ph_d;
	logic [5:0]    cnt_q, cnt_d;
	logic [TW-1:0] tries_q, tries_d;
	logic          exh_q, exh_d;
	logic          is_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crde_pkg::ST_IDLE;
			ph_q    <= 2'd0;
			cnt_q   <= 6'd0;
			tries_q <= '0;
			exh_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			cnt_q   <= cnt_d;
			tries_q <= tries_d;
			exh_q   <= exh_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ph_d          = 2'd0;
		cnt_d         = cnt_q;
		tries_d       = tries_q;
		exh_d         = exh_q;
		cmd.op        = crde_pkg::OP_NONE;
		cmd.msel      = crde_pkg::MS_IDENT;
		cmd.exhausted = exh_q;
		s_tready      = 1'b0;
		is_range      = status.kind == crde_pkg::KIND_RANGE;

		// three phases per 64-bit product
		if (state_q == crde_pkg::ST_M1 || state_q == crde_pkg::ST_M2 ||
		    state_q == crde_pkg::ST_M3 || state_q == crde_pkg::ST_M4) begin
			unique case (ph_q)
				2'd0:    cmd.op = crde_pkg::OP_MUL0;
				2'd1:    cmd.op = crde_pkg::OP_MUL1;
				default: cmd.op = crde_pkg::OP_MUL2;
			endcase
			ph_d = ph_q + 2'd1;
		end

		unique case (state_q)
			crde_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = crde_pkg::OP_LOAD;
					state_d = crde_pkg::ST_DISPATCH;
				end
			end
			crde_pkg::ST_DISPATCH: begin
				tries_d = '0;
				exh_d   = 1'b0;
				if (is_range) begin
					state_d = status.empty ? crde_pkg::ST_DONE : crde_pkg::ST_THR_INIT;
				end else if (status.kind == crde_pkg::KIND_RAW ||
				             status.kind == crde_pkg::KIND_HALF ||
				             status.kind == crde_pkg::KIND_UNIT ||
				             status.kind == crde_pkg::KIND_SPLIT) begin
					state_d = crde_pkg::ST_M1;
				end else begin
					state_d = crde_pkg::ST_DONE;
				end
			end
			crde_pkg::ST_SEED: begin
				cmd.op  = crde_pkg::OP_SEED;
				state_d = crde_pkg::ST_M1;
			end
			crde_pkg::ST_M1: begin
				cmd.msel = crde_pkg::MS_IDENT;
				if (ph_q == 2'd2) state_d = crde_pkg::ST_X1;
			end
			crde_pkg::ST_X1: begin
				cmd.op  = crde_pkg::OP_XOR_ACC;
				state_d = (status.kind == crde_pkg::KIND_SPLIT) ?
				          crde_pkg::ST_MIX : crde_pkg::ST_M2;
			end
			crde_pkg::ST_M2: begin
				cmd.msel = crde_pkg::MS_IDX;
				if (ph_q == 2'd2) state_d = crde_pkg::ST_X2;
			end
			crde_pkg::ST_X2: begin
				cmd.op  = crde_pkg::OP_XOR_ACC;
				state_d = crde_pkg::ST_MIX;
			end
			crde_pkg::ST_MIX: begin
				cmd.op  = crde_pkg::OP_MIX_ADD;
				state_d = crde_pkg::ST_M3;
			end
			crde_pkg::ST_M3: begin
				cmd.msel = crde_pkg::MS_MIX1;
				if (ph_q == 2'd2) state_d = crde_pkg::ST_X3;
			end
			crde_pkg::ST_X3: begin
				cmd.op  = crde_pkg::OP_SH27;
				state_d = crde_pkg::ST_M4;
			end
			crde_pkg::ST_M4: begin
				cmd.msel = crde_pkg::MS_MIX2;
				if (ph_q == 2'd2) state_d = crde_pkg::ST_X4;
			end
			crde_pkg::ST_X4: begin
				cmd.op  = crde_pkg::OP_SH31;
				state_d = is_range ? crde_pkg::ST_EVAL : crde_pkg::ST_DONE;
			end
			crde_pkg::ST_EVAL: begin
				if (status.draw_ge_thr || tries_q == LAST_TRY) begin
					exh_d   = !status.draw_ge_thr;
					state_d = crde_pkg::ST_MOD_INIT;
				end else begin
					// reject: step the draw index and redraw
					cmd.op  = crde_pkg::OP_IDX_INC;
					tries_d = tries_q + 1'b1;
					state_d = crde_pkg::ST_SEED;
				end
			end
			crde_pkg::ST_THR_INIT: begin
				cmd.op  = crde_pkg::OP_DIV_THR;
				cnt_d   = 6'd0;
				state_d = crde_pkg::ST_THR_DIV;
			end
			crde_pkg::ST_THR_DIV: begin
				cmd.op = crde_pkg::OP_DIV_STEP;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == LAST_STEP) state_d = crde_pkg::ST_THR_SAVE;
			end
			crde_pkg::ST_THR_SAVE: begin
				cmd.op  = crde_pkg::OP_SAVE_THR;
				state_d = crde_pkg::ST_M1;
			end
			crde_pkg::ST_MOD_INIT: begin
				cmd.op  = crde_pkg::OP_DIV_MOD;
				cnt_d   = 6'd0;
				state_d = crde_pkg::ST_MOD_DIV;
			end
			crde_pkg::ST_MOD_DIV: begin
				cmd.op = crde_pkg::OP_DIV_STEP;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == LAST_STEP) state_d = crde_pkg::ST_DONE;
			end
			crde_pkg::ST_DONE: begin
				// hold until the output register is free
				if (status.out_free) begin
					cmd.op  = crde_pkg::OP_OUT;
					state_d = crde_pkg::ST_IDLE;
				end
			end
			default: state_d = crde_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[hdl/counter_rng_draw_engine_top.sv]
`default_nettype none
// Raw, half and unit draws hash ident and draw index, then mix; split skips the index; an
// empty range skips to output; range draws get a threshold, then draw (tries 1..MAX_TRIES).
// Throughput: one word at a time; each 64-bit product takes three passes of one 32x32
// multiplier and each modulo 64 steps of a one-bit-per-cycle restoring divider.
// Reset: arst_n clears the controller and the output valid; datapath registers are not reset.
module counter_rng_draw_engine_top #(
	parameter int unsigned MAX_TRIES = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// stream_seed, stream_ident, draw_index, lower_bound, upper_bound, child_ident
	input  wire logic [383:0] s_tdata,
	// req_type
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result_value, result_stream
	output logic [127:0]      m_tdata,
	// tries_exhausted
	output logic [0:0]        m_tuser
);

	crde_pkg::dp_cmd_t    cmd;
	crde_pkg::dp_status_t status;

	crde_ctrl #(
		.MAX_TRIES(MAX_TRIES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (cmd),
		.status  (status)
	);

	crde_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

`ifndef SYNTH
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (cmd.op == crde_pkg::OP_LOAD))
		else $error("accepted word not loaded");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == crde_pkg::OP_OUT) |-> (!m_tvalid || m_tready))
		else $error("pending result overwritten");

	a_flag_only_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[127:64] == 64'd0))
		else $error("exhausted flag outside range draw");
`endif

endmodule
`default_nettype wire

[test/counter_rng_draw_engine_top_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module counter_rng_draw_engine_top_test;

	localparam int unsigned TRY_LIMIT = 64;
	localparam int unsigned IDLE_LIMIT = 40000;

	typedef struct {
		logic [63:0] value;
		logic [63:0] stream;
		logic        exhausted;
	} draw_result_t;

	class draw_scoreboard;
		draw_result_t pending[$];
		int errors;
		int checked;
		int kind_seen[8];
		int exhausted_seen;

		function logic [63:0] mix(logic [63:0] x);
			x = x + crde_pkg::GOLDEN_C;
			x = (x ^ (x >> 30)) * crde_pkg::MIX1_C;
			x = (x ^ (x >> 27)) * crde_pkg::MIX2_C;
			return x ^ (x >> 31);
		endfunction

		function logic [63:0] hash_draw(logic [63:0] seed, logic [63:0] ident,
				logic [63:0] idx);
			return mix(seed ^ (ident * crde_pkg::GOLDEN_C) ^ (idx * crde_pkg::DRAW_C));
		endfunction

		function void note_request(logic [2:0] kind, logic [383:0] data);
			logic [63:0] seed, ident, idx, lo, hi, child, n, thr, w;
			draw_result_t r;
			bit ok;
			seed = data[63:0];
			ident = data[127:64];
			idx = data[191:128];
			lo = data[255:192];
			hi = data[319:256];
			child = data[383:320];
			r.value = '0;
			r.stream = '0;
			r.exhausted = 1'b0;
			kind_seen[kind]++;
			case (kind)
				crde_pkg::KIND_RAW: r.value = hash_draw(seed, ident, idx);
				crde_pkg::KIND_HALF: r.value = hash_draw(seed, ident, idx) >> 32;
				crde_pkg::KIND_UNIT: r.value = hash_draw(seed, ident, idx) >> 40;
				crde_pkg::KIND_SPLIT: begin
					r.value = mix(seed ^ (ident * crde_pkg::GOLDEN_C));
					r.stream = child;
				end
				crde_pkg::KIND_RANGE: begin
					if (hi <= lo) begin
						r.value = lo;
					end else begin
						n = hi - lo;
						thr = (64'd0 - n) % n;
						ok = 0;
						w = '0;
						for (int t = 0; t < TRY_LIMIT; t++) begin
							w = hash_draw(seed, ident, idx);
							if (w >= thr) begin
								ok = 1;
								break;
							end
							idx = idx + 1;
						end
						r.exhausted = !ok;
						r.value = lo + (w % n);
					end
				end
				default: ;
			endcase
			if (r.exhausted)
				exhausted_seen++;
			pending.push_back(r);
		endfunction

		function void check_result(logic [127:0] data, logic [0:0] flags);
			draw_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word %h", data);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (data[63:0] !== e.value) begin
				$error("result_value: expected %h, got %h", e.value, data[63:0]);
				errors++;
			end
			if (data[127:64] !== e.stream) begin
				$error("result_stream: expected %h, got %h", e.stream, data[127:64]);
				errors++;
			end
			if (flags[0] !== e.exhausted) begin
				$error("tries_exhausted: expected %b, got %b", e.exhausted, flags[0]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [383:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [0:0] m_tuser;

	draw_scoreboard board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int idle_cycles = 0;

	counter_rng_draw_engine_top #(.MAX_TRIES(TRY_LIMIT)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// note requests and check results at the rising edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			board.note_request(s_tuser, s_tdata);
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d quiet cycles", idle_cycles);
			$display("counter_rng_draw_engine_top_test: errors");
			$finish;
		end
	end

	// receiver: random stalls, or a long counted hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_word(logic [2:0] kind, logic [63:0] seed, logic [63:0] ident,
			logic [63:0] idx, logic [63:0] lo, logic [63:0] hi, logic [63:0] child);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser <= kind;
		s_tdata <= {child, hi, lo, idx, ident, seed};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_random();
		logic [2:0] kind;
		logic [63:0] lo, hi, n;
		kind = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
		lo = rand64();
		case ($urandom_range(5))
			0: n = 64'($urandom_range(16, 1));
			1: n = 64'(1) << $urandom_range(63);
			2: n = (64'(1) << 63) + 64'($urandom_range(1000));
			3: n = 64'd0 - 64'($urandom_range(1000, 1));
			4: n = 64'd0;
			default: n = rand64();
		endcase
		if ($urandom_range(9) == 0)
			hi = lo - 64'($urandom_range(3));
		else begin
			lo = ($urandom_range(1)) ? 64'($urandom_range(1000)) : lo;
			hi = lo + n;
			// keep the span, ending at the top of the range
			if (hi < lo) begin
				lo = ~n;
				hi = lo + n;
			end
		end
		send_word(kind, rand64(), rand64(), rand64(), lo, hi, rand64());
	endtask

	task automatic drain();
		while (board.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes, every kind, empty range, unknown kinds
		send_word(crde_pkg::KIND_RAW, '0, '0, '0, '0, '0, '0);
		send_word(crde_pkg::KIND_RAW, '1, '1, '1, '1, '1, '1);
		send_word(crde_pkg::KIND_HALF, '1, '0, '1, '0, '1, '0);
		send_word(crde_pkg::KIND_UNIT, '0, '1, '0, '1, '0, '1);
		send_word(crde_pkg::KIND_UNIT, rand64(), rand64(), '1, 0, 0, 0);
		send_word(crde_pkg::KIND_SPLIT, '1, '1, rand64(), 0, 0, '1);
		send_word(crde_pkg::KIND_SPLIT, '0, '0, rand64(), 0, 0, rand64());
		send_word(crde_pkg::KIND_RANGE, rand64(), rand64(), rand64(), 64'd5, 64'd5, 0);
		send_word(crde_pkg::KIND_RANGE, rand64(), rand64(), rand64(), '1, '0, 0);
		send_word(crde_pkg::KIND_RANGE, rand64(), rand64(), '1, 64'd0, 64'd1, 0);
		send_word(crde_pkg::KIND_RANGE, rand64(), rand64(), rand64(), 64'd0, '1, 0);
		send_word(crde_pkg::KIND_RANGE, rand64(), rand64(), rand64(), 64'd0,
			64'h8000_0000_0000_0001, 0);
		send_word(crde_pkg::KIND_RANGE, rand64(), rand64(), rand64(), 64'd1, '1, 0);
		send_word(crde_pkg::KIND_RANGE, rand64(), rand64(), '1, 64'd100, 64'd107, 0);
		send_word(3'd5, '1, '1, '1, '1, '1, '1);
		send_word(3'd6, rand64(), rand64(), rand64(), 0, 0, 0);
		send_word(3'd7, rand64(), rand64(), rand64(), 0, 0, 0);

		// long receiver hold-off while requests keep coming
		hold_off = 3000;
		for (int i = 0; i < 20; i++)
			send_random();
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 65; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 65; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			for (int i = 0; i < 280; i++)
				send_random();
			// pause until every expected result is in
			drain();
		end

		repeat (200) @(negedge clk);
		$display("checked %0d results: raw %0d, half %0d, range %0d, unit %0d, split %0d",
			board.checked, board.kind_seen[0], board.kind_seen[1], board.kind_seen[2],
			board.kind_seen[3], board.kind_seen[4]);
		$display("unknown kinds %0d, exhausted range draws %0d",
			board.kind_seen[5] + board.kind_seen[6] + board.kind_seen[7],
			board.exhausted_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("counter_rng_draw_engine_top_test: clean");
		else
			$display("counter_rng_draw_engine_top_test: errors");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
hdl/crde_pkg.sv
hdl/crde_dp.sv
hdl/crde_ctrl.sv
hdl/counter_rng_draw_engine_top.sv
test/counter_rng_draw_engine_top_test.sv
